// ----- rtl/tts_pkg.sv -----
// Shared types, constants and the byte classifier of the text token splitter.
package tts_pkg;

    typedef enum logic [1:0] {
        CLS_WORD  = 2'd0,
        CLS_WHITE = 2'd1,
        CLS_OTHER = 2'd2
    } char_class_t;

    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_UNDER = 8'h5F;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;

    // Result slots of one request, in emission order
    localparam int SLOT_CR   = 0;
    localparam int SLOT_MAIN = 1;
    localparam int SLOT_LF   = 2;
    localparam int NUM_SLOTS = 3;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           main_byte;
        logic                 main_start;
        char_class_t          main_class;
    } tts_result_t;

    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t cls;
        if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h30 && b <= 8'h39) || b == BYTE_UNDER || b == BYTE_DOLLAR)
        begin
            cls = CLS_WORD;
        end
        else if (b == BYTE_SPACE || b == BYTE_CR || b == BYTE_LF || b == BYTE_TAB)
        begin
            cls = CLS_WHITE;
        end
        else
        begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

// ----- rtl/tts_decode.sv -----
// Token state and per-request result decode of the text token splitter.
module tts_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [7:0]          char_byte,
    input  logic                stream_end,
    input  logic                fold_crlf,
    output tts_pkg::tts_result_t result
);
    import tts_pkg::*;

    char_class_t prev_class_reg, prev_class_next;
    logic        token_open_reg, token_open_next;
    logic        cr_held_reg, cr_held_next;

    char_class_t cls;
    char_class_t prev1;
    logic        open1;
    logic        held_emit;
    logic        main_emit;
    logic        last_lf;

    always_comb
    begin
        cls       = classify(char_byte);
        held_emit = cr_held_reg && (char_byte != BYTE_LF);
        main_emit = !(fold_crlf && char_byte == BYTE_CR);
        last_lf   = main_emit && (char_byte == BYTE_LF);
        // a held CR passed on first counts as an open whitespace token
        open1     = token_open_reg || held_emit;
        prev1     = held_emit ? CLS_WHITE : prev_class_reg;

        result                  = '0;
        result.mask[SLOT_CR]    = held_emit;
        result.mask[SLOT_MAIN]  = main_emit;
        result.mask[SLOT_LF]    = stream_end && !last_lf;
        result.main_byte        = char_byte;
        result.main_class       = cls;
        result.main_start       = !open1 || (cls != prev1) || (cls == CLS_WHITE);

        if (stream_end)
        begin
            prev_class_next = CLS_OTHER;
            token_open_next = 1'b0;
            cr_held_next    = 1'b0;
        end
        else
        begin
            prev_class_next = main_emit ? cls : prev1;
            token_open_next = open1 || main_emit;
            cr_held_next    = !main_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_class_reg <= CLS_OTHER;
            token_open_reg <= 1'b0;
            cr_held_reg    <= 1'b0;
        end
        else if (load)
        begin
            prev_class_reg <= prev_class_next;
            token_open_reg <= token_open_next;
            cr_held_reg    <= cr_held_next;
        end
    end

endmodule

// ----- rtl/tts_out_buffer.sv -----
// Result register of the text token splitter: holds up to three results of one request.
module tts_out_buffer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tts_pkg::tts_result_t result,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                token_start,
    output logic [1:0]          char_class,
    output logic                run_last
);
    import tts_pkg::*;

    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [7:0]           main_byte_reg;
    logic                 main_start_reg;
    char_class_t          main_class_reg;

    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] remain;
    logic                 take;

    always_comb
    begin
        sel       = mask_reg & (~mask_reg + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
        remain    = mask_reg & ~sel;
        out_valid = |mask_reg;
        run_last  = (remain == '0);
        take      = out_valid && out_ready;
        free      = !out_valid || (take && run_last);

        if (sel[SLOT_MAIN])
        begin
            out_byte    = main_byte_reg;
            token_start = main_start_reg;
            char_class  = main_class_reg;
        end
        else
        begin
            // held CR and appended LF are both whitespace and always start a token
            out_byte    = sel[SLOT_CR] ? BYTE_CR : BYTE_LF;
            token_start = 1'b1;
            char_class  = CLS_WHITE;
        end

        if (load)
        begin
            mask_next = result.mask;
        end
        else if (take)
        begin
            mask_next = remain;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            main_byte_reg  <= result.main_byte;
            main_start_reg <= result.main_start;
            main_class_reg <= result.main_class;
        end
    end

endmodule

// ----- rtl/text_token_splitter_unit.sv -----
// Top level of the text token splitter: input register, decode and result buffer.
//
// Usage:
//   Input channel (in_valid/in_ready, char_byte, stream_end) takes one raw byte
//   per request; stream_end marks the final byte of a stream. Output channel
//   (out_valid/out_ready) delivers results: out_byte, token_start, char_class
//   and run_last, which flags the last result caused by one input request.
//   Configuration channel (cfg_valid/cfg_ready, fold_crlf) writes the CRLF
//   folding bit; write it only while the block is idle.
// Path: a request enters the input register when accepted and moves on into
//   the result buffer once the buffer is free; out_valid rises when the
//   result buffer holds a request that yields at least one result.
// Throughput: one request per cycle while each request yields one result and
//   out_ready stays high. A request that yields two or three results (passed-on
//   held CR, appended LF) occupies the result buffer until all of them are
//   taken; a request that yields none passes through without taking an output cycle.
// Reset: clears folding (off), the token state and both pipeline registers.
// Stall: when out_ready is low the result buffer holds, the input register
//   then holds its request, and in_ready drops once both are full.
module text_token_splitter_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       fold_crlf,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       token_start,
    output logic [1:0] char_class,
    output logic       run_last
);
    import tts_pkg::*;

    logic        fold_crlf_reg;
    logic        in_valid_reg;
    logic [7:0]  char_byte_reg;
    logic        stream_end_reg;

    logic        buf_free;
    logic        load;
    tts_result_t result;

    // Config register always takes a write
    assign cfg_ready = 1'b1;

    // Advance the input register into the buffer whenever the buffer drains
    assign load     = in_valid_reg && buf_free;
    assign in_ready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_crlf_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                fold_crlf_reg <= fold_crlf;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
        end
    end

    // Payload of the input register: capture on every accepted request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_byte_reg  <= char_byte;
            stream_end_reg <= stream_end;
        end
    end

    tts_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .char_byte  (char_byte_reg),
        .stream_end (stream_end_reg),
        .fold_crlf  (fold_crlf_reg),
        .result     (result)
    );

    tts_out_buffer u_out_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .result      (result),
        .free        (buf_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .token_start (token_start),
        .char_class  (char_class),
        .run_last    (run_last)
    );

endmodule
